[hdl/assert_macros.svh]
// Assertion macros for the checker of the RGB to HSV converter.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`endif

[hdl/rhc_pkg.sv]
// Types and constants shared by the RGB to HSV converter modules.
// No dependencies.
`default_nettype none

package rhc_pkg;

  typedef logic [1:0] sector_t;

  localparam sector_t SECT_RED   = 2'd0;
  localparam sector_t SECT_GREEN = 2'd1;
  localparam sector_t SECT_BLUE  = 2'd2;

  typedef struct packed {
    sector_t sector;
    logic    diff_neg;
    logic    undef;
  } class_t;

  localparam int CLASS_W     = $bits(class_t);
  localparam int HUE_W       = 13;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

`default_nettype wire

[hdl/rhc_if.sv]
// Valid/ready channel interfaces for the pixel input and the HSV result.
// Depends on rhc_pkg.
`default_nettype none

interface rhc_pixel_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if #(parameter int CHANNEL_BITS = 8);
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::HUE_W-1:0] hue;
  logic [CHANNEL_BITS-1:0]   saturation;
  logic [CHANNEL_BITS-1:0]   brightness;
  logic                      hue_undefined;

  modport source (output valid, hue, saturation, brightness, hue_undefined, input ready);
  modport sink (input valid, hue, saturation, brightness, hue_undefined, output ready);
endinterface

`default_nettype wire

[hdl/rgb_to_hsv_converter.sv]
// RGB to HSV converter, top level; uses rhc_pkg, the channel interfaces, rhc_front,
// rhc_queue and rhc_back. It takes one pixel per clock unless back pressure stalls
// it, and returns one result per pixel in order. Value is the largest channel,
// saturation is chroma times the channel maximum over value, and hue is in units
// of 1/2^HUE_FRAC_BITS degree. The pipeline depth is set by the dividers, which
// resolve one quotient bit per pipeline stage. A four-entry queue separates the
// classifying front end from the dividers, and the output register holds a result
// under back pressure while input goes on until the queue and front end fill.
`default_nettype none

module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  rhc_pixel_if.sink in_ch,
  rhc_hsv_if.source out_ch
);
  import rhc_pkg::*;

  localparam int C  = CHANNEL_BITS;
  localparam int QW = 3 * C + CLASS_W;

  logic          push_valid, push_ready;
  logic [C-1:0]  f_mx, f_delta, f_dmag;
  class_t        f_cls;
  logic [QW-1:0] wr_data, rd_data;
  logic          q_valid, q_ready;

  rhc_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_red    (in_ch.red),
    .in_green  (in_ch.green),
    .in_blue   (in_ch.blue),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_mx   (f_mx),
    .push_delta(f_delta),
    .push_dmag (f_dmag),
    .push_cls  (f_cls)
  );

  assign wr_data = {f_mx, f_delta, f_dmag, f_cls};

  rhc_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data (wr_data),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (rd_data)
  );

  rhc_back #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_mx             (rd_data[QW-1 -: C]),
    .q_delta          (rd_data[QW-C-1 -: C]),
    .q_dmag           (rd_data[QW-2*C-1 -: C]),
    .q_cls            (class_t'(rd_data[CLASS_W-1:0])),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_hue          (out_ch.hue),
    .out_saturation   (out_ch.saturation),
    .out_brightness   (out_ch.brightness),
    .out_hue_undefined(out_ch.hue_undefined)
  );

endmodule

`default_nettype wire

[hdl/rhc_front.sv]
// Front end: accepts pixels, finds max, min and chroma, and classifies the hue sector.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [CHANNEL_BITS-1:0] push_mx,
  output logic [CHANNEL_BITS-1:0] push_delta,
  output logic [CHANNEL_BITS-1:0] push_dmag,
  output rhc_pkg::class_t         push_cls
);
  import rhc_pkg::*;

  logic                    f_v_r;
  logic [CHANNEL_BITS-1:0] mx_r, del_r, dmag_r;
  class_t                  cls_r;

  logic [CHANNEL_BITS-1:0] mx_rg, mx, mn_rg, mn;
  logic [CHANNEL_BITS-1:0] op_a, op_b, dmag;
  class_t                  cls;

  always_comb begin
    mx_rg = (in_red > in_green) ? in_red : in_green;
    mx    = (mx_rg > in_blue) ? mx_rg : in_blue;
    mn_rg = (in_red < in_green) ? in_red : in_green;
    mn    = (mn_rg < in_blue) ? mn_rg : in_blue;

    priority if (in_red >= mx) begin
      cls.sector = SECT_RED;
      op_a       = in_green;
      op_b       = in_blue;
    end else if (in_green >= mx) begin
      cls.sector = SECT_GREEN;
      op_a       = in_blue;
      op_b       = in_red;
    end else begin
      cls.sector = SECT_BLUE;
      op_a       = in_red;
      op_b       = in_green;
    end

    if (op_a >= op_b) begin
      dmag         = op_a - op_b;
      cls.diff_neg = 1'b0;
    end else begin
      dmag         = op_b - op_a;
      cls.diff_neg = 1'b1;
    end
    cls.undef = (mx == mn);
  end

  assign in_ready = !f_v_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_ready) begin
      f_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mx_r   <= mx;
      del_r  <= mx - mn;
      dmag_r <= dmag;
      cls_r  <= cls;
    end
  end

  assign push_valid = f_v_r;
  assign push_mx    = mx_r;
  assign push_delta = del_r;
  assign push_dmag  = dmag_r;
  assign push_cls   = cls_r;

endmodule

`default_nettype wire

[hdl/rhc_queue.sv]
// Short first-in first-out queue between the front end and the divider back end.
// Depends on rhc_pkg.
`default_nettype none

module rhc_queue #(
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);
  import rhc_pkg::*;

  logic [DATA_W-1:0]   mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                push, pop;

  assign wr_ready = (cnt_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[hdl/rhc_back.sv]
// Back end: pipelined restoring dividers for saturation and hue, hue assembly and
// the output register. Depends on rhc_pkg.
`default_nettype none

module rhc_back #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  logic [CHANNEL_BITS-1:0]   q_mx,
  input  logic [CHANNEL_BITS-1:0]   q_delta,
  input  logic [CHANNEL_BITS-1:0]   q_dmag,
  input  rhc_pkg::class_t           q_cls,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rhc_pkg::HUE_W-1:0] out_hue,
  output logic [CHANNEL_BITS-1:0]   out_saturation,
  output logic [CHANNEL_BITS-1:0]   out_brightness,
  output logic                      out_hue_undefined
);
  import rhc_pkg::*;

  localparam int C          = CHANNEL_BITS;
  localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
  localparam int HQ         = $clog2(HUE_SECTOR + 1);
  localparam int NSTG       = (C > HQ) ? C : HQ;
  localparam int RW         = C + NSTG;
  localparam int HW         = $clog2(HUE_FULL);

  logic            v_r    [0:NSTG];
  logic [C-1:0]    mx_r   [0:NSTG];
  logic [C-1:0]    del_r  [0:NSTG];
  class_t          cls_r  [0:NSTG];
  logic [RW-1:0]   srem_r [0:NSTG];
  logic [RW-1:0]   hrem_r [0:NSTG];
  logic [NSTG-1:0] sq_r   [0:NSTG];
  logic [NSTG-1:0] hq_r   [0:NSTG];

  logic               out_v_r;
  logic [HUE_W-1:0]   hue_r;
  logic [C-1:0]       sat_r, bri_r;
  logic               und_r;
  logic               adv;

  assign adv     = !out_v_r || out_ready;
  assign q_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r[0]   <= q_mx;
      del_r[0]  <= q_delta;
      cls_r[0]  <= q_cls;
      srem_r[0] <= (RW'(q_delta) << C) - RW'(q_delta);
      hrem_r[0] <= (RW'(q_dmag) << (HUE_FRAC_BITS + 6)) - (RW'(q_dmag) << (HUE_FRAC_BITS + 2));
      sq_r[0]   <= '0;
      hq_r[0]   <= '0;
    end
  end

  for (genvar gi = 1; gi <= NSTG; gi++) begin : g_div
    localparam int K = NSTG - gi;
    logic [RW-1:0] sdiv, hdiv;
    logic          sbit, hbit;

    assign sdiv = RW'(mx_r[gi-1]) << K;
    assign hdiv = RW'(del_r[gi-1]) << K;
    assign sbit = (srem_r[gi-1] >= sdiv);
    assign hbit = (hrem_r[gi-1] >= hdiv);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi] <= 1'b0;
      end else if (adv) begin
        v_r[gi] <= v_r[gi-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mx_r[gi]   <= mx_r[gi-1];
        del_r[gi]  <= del_r[gi-1];
        cls_r[gi]  <= cls_r[gi-1];
        srem_r[gi] <= sbit ? (srem_r[gi-1] - sdiv) : srem_r[gi-1];
        hrem_r[gi] <= hbit ? (hrem_r[gi-1] - hdiv) : hrem_r[gi-1];
        sq_r[gi]   <= {sq_r[gi-1][NSTG-2:0], sbit};
        hq_r[gi]   <= {hq_r[gi-1][NSTG-2:0], hbit};
      end
    end
  end

  logic [HQ-1:0]       hq;
  logic [HW-1:0]       base, hue_calc;
  logic [HW+HUE_W-1:0] hue_ext;
  class_t              cls_l;

  always_comb begin
    cls_l = cls_r[NSTG];
    hq    = hq_r[NSTG][HQ-1:0];
    unique case (cls_l.sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HW'(2 * HUE_SECTOR);
      SECT_BLUE:  base = HW'(4 * HUE_SECTOR);
      default:    base = '0;
    endcase

    if (cls_l.undef) begin
      hue_calc = '0;
    end else if (!cls_l.diff_neg) begin
      hue_calc = base + HW'(hq);
    end else if (hq == '0) begin
      hue_calc = base;
    end else if (cls_l.sector == SECT_RED) begin
      hue_calc = HW'(HUE_FULL) - HW'(hq);
    end else begin
      hue_calc = base - HW'(hq);
    end
    hue_ext = {{HUE_W{1'b0}}, hue_calc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r <= hue_ext[HUE_W-1:0];
      sat_r <= cls_l.undef ? '0 : sq_r[NSTG][C-1:0];
      bri_r <= mx_r[NSTG];
      und_r <= cls_l.undef;
    end
  end

  assign out_valid         = out_v_r;
  assign out_hue           = hue_r;
  assign out_saturation    = sat_r;
  assign out_brightness    = bri_r;
  assign out_hue_undefined = und_r;

endmodule

`default_nettype wire

[hdl/rhc_checker.sv]
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on assert_macros.svh and rhc_pkg.
`default_nettype none
`include "assert_macros.svh"

module rhc_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rhc_pkg::HUE_W-1:0] out_hue,
  input logic [CHANNEL_BITS-1:0]   out_saturation,
  input logic [CHANNEL_BITS-1:0]   out_brightness,
  input logic                      out_hue_undefined
);

  `RHC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RHC_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_hue) && $stable(out_saturation) && $stable(out_brightness) && $stable(out_hue_undefined))
  `RHC_ASSERT_IMP(a_undef_zero, clk, rst_n, out_valid && out_hue_undefined, out_hue == '0 && out_saturation == '0)
  `RHC_ASSERT_IMP(a_black_undef, clk, rst_n, out_valid && out_brightness == '0, out_hue_undefined)

endmodule

bind rgb_to_hsv_converter rhc_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_rhc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_hue          (out_ch.hue),
  .out_saturation   (out_ch.saturation),
  .out_brightness   (out_ch.brightness),
  .out_hue_undefined(out_ch.hue_undefined)
);

`default_nettype wire

[tb/rgb_to_hsv_converter_tb.sv]
// Self-checking testbench for rgb_to_hsv_converter: directed and random pixels
// against a behavioral HSV predictor, with random stalls on both channels.
// Depends on rhc_pkg, the rhc channel interfaces and the converter RTL.
`default_nettype none

module rgb_to_hsv_converter_tb;
  import rhc_pkg::*;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 4;
  localparam int HUE_SECTOR    = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;
  localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 6;
  localparam int IDLE_PCT      = 21;
  localparam int RANDOM_PIXELS = 850;
  localparam int STEADY_FIRST  = 400;
  localparam int STEADY_LAST   = 550;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 100;
  localparam int NUM_DIRECTED  = 24;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic [HUE_W-1:0] hue;
    chan_t            saturation;
    chan_t            brightness;
    logic             hue_undefined;
  } conversion_t;

  typedef struct {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    bit               typed;
    logic [HUE_W-1:0] hue;
    chan_t            saturation;
    chan_t            brightness;
    logic             hue_undefined;
  } pixel_case_t;

  logic clk = 1'b0;
  logic rst_n;
  logic steady_flow;
  int   cycle_count = 0;
  int   error_count = 0;
  conversion_t pending_hsv[$];

  rhc_pixel_if #(.CHANNEL_BITS(CHANNEL_BITS)) in_ch ();
  rhc_hsv_if #(.CHANNEL_BITS(CHANNEL_BITS)) out_ch ();

  rgb_to_hsv_converter #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Rows with typed expectations are pure primaries, grays and black.
  pixel_case_t directed_cases [NUM_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 13'd0,    8'd0,   8'd0,   1'b1},
    '{8'd255, 8'd255, 8'd255, 1'b1, 13'd0,    8'd0,   8'd255, 1'b1},
    '{8'd255, 8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd255, 1'b0},
    '{8'd0,   8'd255, 8'd0,   1'b1, 13'd1920, 8'd255, 8'd255, 1'b0},
    '{8'd0,   8'd0,   8'd255, 1'b1, 13'd3840, 8'd255, 8'd255, 1'b0},
    '{8'd1,   8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd1,   1'b0},
    '{8'd128, 8'd128, 8'd128, 1'b1, 13'd0,    8'd0,   8'd128, 1'b1},
    '{8'd1,   8'd1,   8'd1,   1'b1, 13'd0,    8'd0,   8'd1,   1'b1},
    '{8'd0,   8'd1,   8'd0,   1'b1, 13'd1920, 8'd255, 8'd1,   1'b0},
    '{8'd0,   8'd0,   8'd1,   1'b1, 13'd3840, 8'd255, 8'd1,   1'b0},
    '{8'd255, 8'd255, 8'd0,   1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd0,   8'd255, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd255, 8'd0,   8'd255, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd255, 8'd0,   8'd1,   1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd255, 8'd255, 8'd254, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd254, 8'd255, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd255, 8'd254, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd170, 8'd85,  8'd0,   1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd10,  8'd200, 8'd100, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd100, 8'd10,  8'd200, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd200, 8'd100, 8'd201, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd85,  8'd170, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd255, 8'd128, 8'd0,   1'b0, 13'd0,    8'd0,   8'd0,   1'b0},
    '{8'd0,   8'd128, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0,   1'b0}
  };

  function automatic conversion_t hsv_of_rgb(input chan_t r, input chan_t g, input chan_t b);
    conversion_t res;
    int mx;
    int mn;
    int delta;
    int sector_base;
    int diff;
    int h;
    mx = (r > g) ? int'(r) : int'(g);
    mx = (mx > int'(b)) ? mx : int'(b);
    mn = (r < g) ? int'(r) : int'(g);
    mn = (mn < int'(b)) ? mn : int'(b);
    delta = mx - mn;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.brightness = chan_t'(mx);
    res.saturation = (mx != 0) ? chan_t'((delta * CHAN_MAX) / mx) : '0;
    res.hue_undefined = (delta == 0);
    h = 0;
    if (delta != 0) begin
      if (r >= mx) begin
        sector_base = 0;
        diff = int'(g) - int'(b);
      end else if (g >= mx) begin
        sector_base = 2 * HUE_SECTOR;
        diff = int'(b) - int'(r);
      end else begin
        sector_base = 4 * HUE_SECTOR;
        diff = int'(r) - int'(g);
      end
      // Signed division in SystemVerilog truncates toward zero.
      h = sector_base + (HUE_SECTOR * diff) / delta;
      if (h < 0) begin
        h += HUE_FULL;
      end
    end
    res.hue = h[HUE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input conversion_t want, input int got,
                                 input int exp_val);
    // Printing stops after PRINT_LIMIT mismatches so that a broken build does not flood the log.
    if (error_count < PRINT_LIMIT) begin
      $display("mismatch %s for rgb (%0d,%0d,%0d): got %0d, expected %0d", field,
               want.red, want.green, want.blue, got, exp_val);
    end
    error_count++;
  endtask

  task automatic send_pixel(input conversion_t want);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red   <= want.red;
    in_ch.green <= want.green;
    in_ch.blue  <= want.blue;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_hsv = {pending_hsv, want};
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rgb_to_hsv_converter_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    conversion_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hsv.size() == 0) begin
        want = '{default: '0};
        report_mismatch("unexpected transaction", want, int'(out_ch.hue), -1);
      end else begin
        want = pending_hsv.pop_front();
        if (out_ch.hue !== want.hue) begin
          report_mismatch("hue", want, int'(out_ch.hue), int'(want.hue));
        end
        if (out_ch.saturation !== want.saturation) begin
          report_mismatch("saturation", want, int'(out_ch.saturation),
                          int'(want.saturation));
        end
        if (out_ch.brightness !== want.brightness) begin
          report_mismatch("brightness", want, int'(out_ch.brightness),
                          int'(want.brightness));
        end
        if (out_ch.hue_undefined !== want.hue_undefined) begin
          report_mismatch("hue_undefined", want, int'(out_ch.hue_undefined),
                          int'(want.hue_undefined));
        end
      end
    end
    out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    conversion_t want;
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t hi;
    chan_t lo;
    int kind;
    rst_n        <= 1'b0;
    steady_flow  <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.red    <= '0;
    in_ch.green  <= '0;
    in_ch.blue   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cases[i]) begin
      want = hsv_of_rgb(directed_cases[i].red, directed_cases[i].green, directed_cases[i].blue);
      if (directed_cases[i].typed) begin
        want.hue           = directed_cases[i].hue;
        want.saturation    = directed_cases[i].saturation;
        want.brightness    = directed_cases[i].brightness;
        want.hue_undefined = directed_cases[i].hue_undefined;
      end
      send_pixel(want);
    end

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      steady_flow <= (i >= STEADY_FIRST) && (i < STEADY_LAST);
      kind = $urandom_range(9);
      r = chan_t'($urandom_range(CHAN_MAX));
      g = chan_t'($urandom_range(CHAN_MAX));
      b = chan_t'($urandom_range(CHAN_MAX));
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          // Two channels tie for the largest value.
          hi = (r > g) ? r : g;
          lo = (r > g) ? g : r;
          case ($urandom_range(2))
            0: begin r = hi; g = hi; b = lo; end
            1: begin r = lo; g = hi; b = hi; end
            default: begin r = hi; g = lo; b = hi; end
          endcase
        end
        7: begin
          r = chan_t'(($urandom_range(1) ? CHAN_MAX : 0) ^ $urandom_range(1));
          g = chan_t'(($urandom_range(1) ? CHAN_MAX : 0) ^ $urandom_range(1));
          b = chan_t'(($urandom_range(1) ? CHAN_MAX : 0) ^ $urandom_range(1));
        end
        8: begin
          g = chan_t'(r + $urandom_range(2) - 1);
          b = chan_t'(r + $urandom_range(2) - 1);
        end
        9: begin
          case ($urandom_range(2))
            0: r = '0;
            1: g = '0;
            default: b = '0;
          endcase
        end
        default: begin
        end
      endcase
      send_pixel(hsv_of_rgb(r, g, b));
    end
    in_ch.valid <= 1'b0;
    steady_flow <= 1'b0;

    while (pending_hsv.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("rgb_to_hsv_converter_tb: PASS");
    end else begin
      $display("rgb_to_hsv_converter_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
